[sv/float_to_decimal_text_assert.svh]
// Assertion macros for the float-to-text RTL.
// Expects clk and rst_n in the scope of every use.
`ifndef FLOAT_TO_DECIMAL_TEXT_ASSERT_SVH
`define FLOAT_TO_DECIMAL_TEXT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define F2DT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define F2DT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/f2dt_pkg.sv]
// Shared types, constants and small functions for the float-to-text block.
// No dependencies.
package f2dt_pkg;

  // Width of the scaled integer (below 1e13) and of internal exponents.
  localparam int BIN_W = 44;
  localparam int EXP_W = 10;
  localparam int TBL_N = 84;
  localparam int Q_DEPTH = 2;

  // Table index of ten to the zero; index i holds ten to the (i - 45).
  localparam logic [6:0] IDX_UNITY = 7'd45;
  // Entries below the low end are scaled up by 2^32, from the high start on down by 2^32.
  localparam logic [6:0] IDX_LOW_END = 7'd32;
  localparam logic [6:0] IDX_HIGH_START = 7'd52;

  // One million as a normalized 24-bit mantissa and unbiased exponent.
  localparam logic [23:0] E6_MANT = 24'hF42400;
  localparam logic signed [EXP_W-1:0] E6_EXP = 10'sd19;

  // Magnitude codes used to sort input words.
  localparam logic [30:0] MAG_INF = 31'h7F800000;
  localparam logic [30:0] MAG_ONE = 31'h3F800000;
  localparam logic [30:0] MAG_TEN_E7 = 31'h4B189680;

  // ASCII characters.
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_E = 8'h65;
  localparam logic [7:0] CH_LBR = 8'h5B;
  localparam logic [7:0] CH_RBR = 8'h5D;
  localparam logic [7:0] CH_UN = 8'h4E;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_UI = 8'h49;
  localparam logic [7:0] CH_UF = 8'h46;

  typedef enum logic [2:0] {
    CLS_NAN,
    CLS_INF,
    CLS_ZERO,
    CLS_FIXED,
    CLS_SCI
  } cls_t;

  // One classified word waiting in the queue.
  typedef struct packed {
    cls_t        cls;
    logic        neg;
    logic [30:0] mag;
  } item_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_NORM,
    B_SEARCH,
    B_MUL,
    B_RND,
    B_TOINT,
    B_BCD,
    B_STR,
    B_SIGN,
    B_DIG,
    B_DOT,
    B_ECHR,
    B_ESGN,
    B_ETEN,
    B_EONE,
    B_TERM
  } bstate_t;

  // Powers of ten from 1e-45 to 1e38, each rounded down to binary32.
  localparam logic [31:0] POW10_FLOOR [TBL_N] = '{
    32'h00000000, 32'h00000007, 32'h00000047, 32'h000002c9, 32'h00001be0, 32'h000116c2,
    32'h000ae397, 32'h006ce3ee, 32'h02081cea, 32'h03aa2424, 32'h0554ad2d, 32'h0704ec3c,
    32'h08a6274b, 32'h0a4fb11e, 32'h0c01ceb3, 32'h0da2425f, 32'h0f4ad2f7, 32'h10fd87b5,
    32'h129e74d1, 32'h14461206, 32'h15f79687, 32'h179abe14, 32'h19416d9a, 32'h1af1c900,
    32'h1c971da0, 32'h1e3ce508, 32'h1fec1e4a, 32'h219392ee, 32'h233877aa, 32'h24e69594,
    32'h26901d7c, 32'h283424dc, 32'h29e12e13, 32'h2b8cbccc, 32'h2d2febff, 32'h2edbe6fe,
    32'h3089705f, 32'h322bcc77, 32'h33d6bf94, 32'h358637bd, 32'h3727c5ac, 32'h38d1b717,
    32'h3a83126e, 32'h3c23d70a, 32'h3dcccccc, 32'h3f7fffff, 32'h411fffff, 32'h42c7ffff,
    32'h4479ffff, 32'h461c3fff, 32'h47c34fff, 32'h497423ff, 32'h4b18967f, 32'h4cbebc1f,
    32'h4e6e6b27, 32'h501502f8, 32'h51ba43b7, 32'h5368d4a5, 32'h551184e7, 32'h56b5e620,
    32'h58635fa9, 32'h5a0e1bc9, 32'h5bb1a2bc, 32'h5d5e0b6b, 32'h5f0ac723, 32'h60ad78eb,
    32'h6258d726, 32'h64078678, 32'h65a96816, 32'h6753c21b, 32'h69045951, 32'h6aa56fa5,
    32'h6c4ecb8f, 32'h6e013f39, 32'h6fa18f07, 32'h7149f2c9, 32'h72fc6f7c, 32'h749dc5ad,
    32'h76453719, 32'h77f684df, 32'h799a130b, 32'h7b4097ce, 32'h7cf0bdc2, 32'h7e967699
  };

  // Inverse powers of ten, 1e45 down to 1e-38; the outer 32 entries at each end carry 2^-32 or 2^32.
  localparam logic [31:0] POW10_INV [TBL_N] = '{
    32'h7a335dbf, 32'h788f7e32, 32'h76e596b7, 32'h7537abc6, 32'h7392efd1, 32'h71eb194f,
    32'h703c143f, 32'h6e967699, 32'h6cf0bdc2, 32'h6b4097cf, 32'h699a130c, 32'h67f684df,
    32'h66453719, 32'h649dc5ae, 32'h62fc6f7c, 32'h6149f2ca, 32'h5fa18f08, 32'h5e013f3a,
    32'h5c4ecb8f, 32'h5aa56fa6, 32'h59045952, 32'h5753c21c, 32'h55a96816, 32'h54078678,
    32'h5258d726, 32'h50ad78ec, 32'h4f0ac723, 32'h4d5e0b6b, 32'h4bb1a2bc, 32'h4a0e1bca,
    32'h48635faa, 32'h46b5e621, 32'h551184e7, 32'h5368d4a5, 32'h51ba43b7, 32'h501502f9,
    32'h4e6e6b28, 32'h4cbebc20, 32'h4b189680, 32'h49742400, 32'h47c35000, 32'h461c4000,
    32'h447a0000, 32'h42c80000, 32'h41200000, 32'h3f800000, 32'h3dcccccd, 32'h3c23d70b,
    32'h3a83126f, 32'h38d1b718, 32'h3727c5ad, 32'h358637be, 32'h43d6bf95, 32'h422bcc78,
    32'h40897060, 32'h3edbe6ff, 32'h3d2febff, 32'h3b8cbccc, 32'h39e12e13, 32'h383424dd,
    32'h36901d7d, 32'h34e69595, 32'h333877aa, 32'h319392ef, 32'h2fec1e4a, 32'h2e3ce509,
    32'h2c971da1, 32'h2af1c900, 32'h29416d9a, 32'h279abe15, 32'h25f79687, 32'h24461206,
    32'h229e74d2, 32'h20fd87b5, 32'h1f4ad2f8, 32'h1da24260, 32'h1c01ceb3, 32'h1a4fb11f,
    32'h18a6274b, 32'h1704ec3d, 32'h1554ad2e, 32'h13aa2425, 32'h12081cea, 32'h1059c7dc
  };

  // Character of the fixed texts for NaN, infinity and zero.
  function automatic logic [7:0] str_char(cls_t cls, logic neg, logic [2:0] pos);
    logic [7:0] c;
    c = CH_NUL;
    case (cls)
      CLS_NAN: begin
        case (pos)
          3'd0: c = CH_LBR;
          3'd1: c = CH_UN;
          3'd2: c = CH_LA;
          3'd3: c = CH_UN;
          3'd4: c = CH_RBR;
          default: c = CH_NUL;
        endcase
      end
      CLS_INF: begin
        case (pos)
          3'd0: c = CH_LBR;
          3'd1: c = neg ? CH_MINUS : CH_PLUS;
          3'd2: c = CH_UI;
          3'd3: c = CH_UN;
          3'd4: c = CH_UF;
          3'd5: c = CH_RBR;
          default: c = CH_NUL;
        endcase
      end
      default: c = CH_ZERO;
    endcase
    return c;
  endfunction

  // Position of the final character of those fixed texts.
  function automatic logic [2:0] str_last(cls_t cls);
    logic [2:0] n;
    case (cls)
      CLS_NAN: n = 3'd4;
      CLS_INF: n = 3'd5;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // Tens digit of a decimal exponent below 64.
  function automatic logic [3:0] dec_tens(logic [5:0] v);
    logic [3:0] t;
    if (v >= 6'd60) t = 4'd6;
    else if (v >= 6'd50) t = 4'd5;
    else if (v >= 6'd40) t = 4'd4;
    else if (v >= 6'd30) t = 4'd3;
    else if (v >= 6'd20) t = 4'd2;
    else if (v >= 6'd10) t = 4'd1;
    else t = 4'd0;
    return t;
  endfunction

  // Ones digit of a decimal exponent below 64.
  function automatic logic [3:0] dec_ones(logic [5:0] v);
    logic [3:0] t;
    logic [5:0] r;
    t = dec_tens(v);
    r = v - {t[2:0], 3'b000} - {1'b0, t, 1'b0};
    return r[3:0];
  endfunction

endpackage

[sv/f2dt_front.sv]
// Front end: takes input words and sorts them into the five text forms.
// Depends on f2dt_pkg.
module f2dt_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       in_value_bits,
  input  logic              q_full,
  output logic              q_push,
  output f2dt_pkg::item_t   q_item
);

  logic [30:0] mag;

  assign mag      = in_value_bits[30:0];
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Sort the word by its magnitude code; positive floats order like integers.
  always_comb begin
    q_item.neg = in_value_bits[31];
    q_item.mag = mag;
    if (mag > f2dt_pkg::MAG_INF) begin
      q_item.cls = f2dt_pkg::CLS_NAN;
    end else if (mag == f2dt_pkg::MAG_INF) begin
      q_item.cls = f2dt_pkg::CLS_INF;
    end else if (mag == '0) begin
      q_item.cls = f2dt_pkg::CLS_ZERO;
    end else if (mag >= f2dt_pkg::MAG_ONE && mag < f2dt_pkg::MAG_TEN_E7) begin
      q_item.cls = f2dt_pkg::CLS_FIXED;
    end else begin
      q_item.cls = f2dt_pkg::CLS_SCI;
    end
  end

endmodule

[sv/f2dt_queue.sv]
// Two-entry queue of classified words between the front and back ends.
// Depends on f2dt_pkg.
module f2dt_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  f2dt_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output f2dt_pkg::item_t q_item
);

  f2dt_pkg::item_t mem_r [f2dt_pkg::Q_DEPTH];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      count_r, count_nxt;
  logic            do_push, do_pop;

  assign full    = (count_r == 2'(f2dt_pkg::Q_DEPTH));
  assign q_valid = (count_r != 2'd0);
  assign q_item  = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[sv/f2dt_back.sv]
// Back end: scales the value, converts it to decimal digits and emits the text.
// Depends on f2dt_pkg and float_to_decimal_text_assert.svh.
`include "float_to_decimal_text_assert.svh"
module f2dt_back #(
  parameter int MAX_DIGITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  f2dt_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_character,
  output logic            out_last,
  output logic [4:0]      out_char_count
);

  localparam int BCD_W = 4 * MAX_DIGITS;
  localparam int DIG_IW = $clog2(MAX_DIGITS);
  localparam int BIN_W = f2dt_pkg::BIN_W;
  localparam int EXP_W = f2dt_pkg::EXP_W;

  f2dt_pkg::bstate_t        state_r, state_nxt;
  f2dt_pkg::item_t          item_r, item_nxt;
  logic [23:0]              a_m_r, a_m_nxt, b_m_r, b_m_nxt;
  logic signed [EXP_W-1:0]  a_e_r, a_e_nxt, b_e_r, b_e_nxt;
  logic [47:0]              prod_r, prod_nxt;
  logic signed [EXP_W-1:0]  esum_r, esum_nxt;
  logic                     pass_r, pass_nxt;
  logic [6:0]               idx_r, idx_nxt;
  logic [BIN_W-1:0]         bin_r, bin_nxt;
  logic [BCD_W-1:0]         bcd_r, bcd_nxt;
  logic [5:0]               bitc_r, bitc_nxt;
  logic [DIG_IW-1:0]        dig_r, dig_nxt;
  logic [2:0]               si_r, si_nxt;
  logic [4:0]               cnt_r, cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [7:0]               out_character_r, out_character_nxt;
  logic                     out_last_r, out_last_nxt;
  logic [4:0]               out_char_count_r, out_char_count_nxt;

  logic                     emit_ok;
  logic                     hit;
  logic [31:0]              inv_word;
  logic [5:0]               ae;
  logic                     e_neg;
  logic [3:0]               e_tens, e_ones;
  logic [DIG_IW-1:0]        lead;
  logic [3:0]               cur_dig;

  // Rounding of the product to a 24-bit mantissa, nearest even.
  logic                     p_hi, p_g, p_st, p_up;
  logic [23:0]              p_mant;
  logic [24:0]              p_sum;
  logic signed [EXP_W-1:0]  p_exp;
  logic [23:0]              r_mant;
  logic signed [EXP_W-1:0]  r_exp;

  assign emit_ok = !out_valid_r || out_ready;
  assign hit = (idx_r == '0) || (f2dt_pkg::POW10_FLOOR[idx_r][30:0] < item_r.mag);
  assign inv_word = f2dt_pkg::POW10_INV[idx_r];
  assign e_neg = (idx_r < f2dt_pkg::IDX_UNITY);
  assign ae = e_neg ? 6'(f2dt_pkg::IDX_UNITY - idx_r) : 6'(idx_r - f2dt_pkg::IDX_UNITY);
  assign e_tens = f2dt_pkg::dec_tens(ae);
  assign e_ones = f2dt_pkg::dec_ones(ae);
  assign cur_dig = bcd_r[4*dig_r +: 4];

  always_comb begin
    p_hi   = prod_r[47];
    p_mant = p_hi ? prod_r[47:24] : prod_r[46:23];
    p_g    = p_hi ? prod_r[23] : prod_r[22];
    p_st   = p_hi ? (|prod_r[22:0]) : (|prod_r[21:0]);
    p_exp  = esum_r + (p_hi ? EXP_W'(1) : EXP_W'(0));
    p_up   = p_g && (p_st || p_mant[0]);
    p_sum  = {1'b0, p_mant} + {24'd0, p_up};
    if (p_sum[24]) begin
      r_mant = 24'h800000;
      r_exp  = p_exp + EXP_W'(1);
    end else begin
      r_mant = p_sum[23:0];
      r_exp  = p_exp;
    end
  end

  // Highest nonzero digit, but never below the units digit of the six decimals.
  always_comb begin
    lead = DIG_IW'(6);
    for (int i = 7; i < MAX_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] != 4'd0) begin
        lead = DIG_IW'(i);
      end
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      f2dt_pkg::B_IDLE: begin
        if (q_valid) begin
          case (q_item.cls)
            f2dt_pkg::CLS_FIXED: state_nxt = f2dt_pkg::B_MUL;
            f2dt_pkg::CLS_SCI:
              state_nxt = (q_item.mag[30:23] == 8'd0) ? f2dt_pkg::B_NORM : f2dt_pkg::B_SEARCH;
            default: state_nxt = f2dt_pkg::B_STR;
          endcase
        end
      end
      f2dt_pkg::B_NORM: if (a_m_r[23]) state_nxt = f2dt_pkg::B_SEARCH;
      f2dt_pkg::B_SEARCH: if (hit) state_nxt = f2dt_pkg::B_MUL;
      f2dt_pkg::B_MUL: state_nxt = f2dt_pkg::B_RND;
      f2dt_pkg::B_RND: state_nxt = pass_r ? f2dt_pkg::B_TOINT : f2dt_pkg::B_MUL;
      f2dt_pkg::B_TOINT: state_nxt = f2dt_pkg::B_BCD;
      f2dt_pkg::B_BCD: if (bitc_r == 6'(BIN_W - 1)) state_nxt = f2dt_pkg::B_SIGN;
      f2dt_pkg::B_STR: begin
        if (emit_ok && si_r == f2dt_pkg::str_last(item_r.cls)) state_nxt = f2dt_pkg::B_TERM;
      end
      f2dt_pkg::B_SIGN: if (!item_r.neg || emit_ok) state_nxt = f2dt_pkg::B_DIG;
      f2dt_pkg::B_DIG: begin
        if (emit_ok) begin
          if (dig_r == DIG_IW'(6)) begin
            state_nxt = f2dt_pkg::B_DOT;
          end else if (dig_r == '0) begin
            state_nxt = (item_r.cls == f2dt_pkg::CLS_SCI) ? f2dt_pkg::B_ECHR : f2dt_pkg::B_TERM;
          end
        end
      end
      f2dt_pkg::B_DOT: if (emit_ok) state_nxt = f2dt_pkg::B_DIG;
      f2dt_pkg::B_ECHR: begin
        if (emit_ok) begin
          if (e_neg) state_nxt = f2dt_pkg::B_ESGN;
          else state_nxt = (e_tens != 4'd0) ? f2dt_pkg::B_ETEN : f2dt_pkg::B_EONE;
        end
      end
      f2dt_pkg::B_ESGN: begin
        if (emit_ok) state_nxt = (e_tens != 4'd0) ? f2dt_pkg::B_ETEN : f2dt_pkg::B_EONE;
      end
      f2dt_pkg::B_ETEN: if (emit_ok) state_nxt = f2dt_pkg::B_EONE;
      f2dt_pkg::B_EONE: if (emit_ok) state_nxt = f2dt_pkg::B_TERM;
      f2dt_pkg::B_TERM: if (emit_ok) state_nxt = f2dt_pkg::B_IDLE;
      default: state_nxt = f2dt_pkg::B_IDLE;
    endcase
  end

  // Datapath and output word logic.
  always_comb begin
    logic                    load;
    logic [7:0]              ch;
    logic signed [EXP_W-1:0] sh;
    logic signed [EXP_W-1:0] rsh;
    logic [BIN_W-1:0]        ext;
    logic [BCD_W-1:0]        adj;
    load = 1'b0;
    ch = f2dt_pkg::CH_NUL;
    sh = '0;
    rsh = '0;
    ext = '0;
    adj = '0;
    q_pop = 1'b0;
    item_nxt = item_r;
    a_m_nxt = a_m_r;
    a_e_nxt = a_e_r;
    b_m_nxt = b_m_r;
    b_e_nxt = b_e_r;
    prod_nxt = prod_r;
    esum_nxt = esum_r;
    pass_nxt = pass_r;
    idx_nxt = idx_r;
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    bitc_nxt = bitc_r;
    dig_nxt = dig_r;
    si_nxt = si_r;
    cnt_nxt = cnt_r;
    out_last_nxt = out_last_r;
    out_char_count_nxt = out_char_count_r;
    out_character_nxt = out_character_r;
    case (state_r)
      f2dt_pkg::B_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          item_nxt = q_item;
          a_m_nxt = {(q_item.mag[30:23] != 8'd0), q_item.mag[22:0]};
          if (q_item.mag[30:23] == 8'd0) begin
            a_e_nxt = -EXP_W'(126);
          end else begin
            a_e_nxt = $signed({2'b00, q_item.mag[30:23]}) - EXP_W'(127);
          end
          b_m_nxt = f2dt_pkg::E6_MANT;
          b_e_nxt = f2dt_pkg::E6_EXP;
          pass_nxt = 1'b1;
          idx_nxt = 7'(f2dt_pkg::TBL_N - 1);
          si_nxt = '0;
          cnt_nxt = '0;
        end
      end
      // Subnormal input: shift the mantissa up one bit a cycle.
      f2dt_pkg::B_NORM: begin
        if (!a_m_r[23]) begin
          a_m_nxt = {a_m_r[22:0], 1'b0};
          a_e_nxt = a_e_r - EXP_W'(1);
        end
      end
      // Walk the power-of-ten table downward until an entry lies below the value.
      f2dt_pkg::B_SEARCH: begin
        if (hit) begin
          b_m_nxt = {1'b1, inv_word[22:0]};
          b_e_nxt = $signed({2'b00, inv_word[30:23]}) - EXP_W'(127);
          if (idx_r < f2dt_pkg::IDX_LOW_END) begin
            b_e_nxt = $signed({2'b00, inv_word[30:23]}) - EXP_W'(127) + EXP_W'(32);
          end else if (idx_r >= f2dt_pkg::IDX_HIGH_START) begin
            b_e_nxt = $signed({2'b00, inv_word[30:23]}) - EXP_W'(127) - EXP_W'(32);
          end
          pass_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r - 7'd1;
        end
      end
      f2dt_pkg::B_MUL: begin
        prod_nxt = a_m_r * b_m_r;
        esum_nxt = a_e_r + b_e_r;
      end
      f2dt_pkg::B_RND: begin
        a_m_nxt = r_mant;
        a_e_nxt = r_exp;
        if (!pass_r) begin
          b_m_nxt = f2dt_pkg::E6_MANT;
          b_e_nxt = f2dt_pkg::E6_EXP;
          pass_nxt = 1'b1;
        end
      end
      // Truncate the scaled float to an integer.
      f2dt_pkg::B_TOINT: begin
        ext = {{(BIN_W-24){1'b0}}, a_m_r};
        sh = a_e_r - EXP_W'(23);
        if (!sh[EXP_W-1]) begin
          bin_nxt = ext << sh[4:0];
        end else begin
          rsh = -sh;
          if (rsh >= EXP_W'(24)) bin_nxt = '0;
          else bin_nxt = ext >> rsh[4:0];
        end
        bcd_nxt = '0;
        bitc_nxt = '0;
      end
      // Binary to BCD, one bit a cycle.
      f2dt_pkg::B_BCD: begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
          adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3 : bcd_r[4*i +: 4];
        end
        bcd_nxt = {adj[BCD_W-2:0], bin_r[BIN_W-1]};
        bin_nxt = {bin_r[BIN_W-2:0], 1'b0};
        bitc_nxt = bitc_r + 6'd1;
      end
      f2dt_pkg::B_STR: begin
        load = 1'b1;
        ch = f2dt_pkg::str_char(item_r.cls, item_r.neg, si_r);
        if (emit_ok) si_nxt = si_r + 3'd1;
      end
      f2dt_pkg::B_SIGN: begin
        dig_nxt = lead;
        load = item_r.neg;
        ch = f2dt_pkg::CH_MINUS;
      end
      f2dt_pkg::B_DIG: begin
        load = 1'b1;
        ch = f2dt_pkg::CH_ZERO + {4'd0, cur_dig};
        if (emit_ok && dig_r != '0) dig_nxt = dig_r - DIG_IW'(1);
      end
      f2dt_pkg::B_DOT: begin
        load = 1'b1;
        ch = f2dt_pkg::CH_DOT;
      end
      f2dt_pkg::B_ECHR: begin
        load = 1'b1;
        ch = f2dt_pkg::CH_E;
      end
      f2dt_pkg::B_ESGN: begin
        load = 1'b1;
        ch = f2dt_pkg::CH_MINUS;
      end
      f2dt_pkg::B_ETEN: begin
        load = 1'b1;
        ch = f2dt_pkg::CH_ZERO + {4'd0, e_tens};
      end
      f2dt_pkg::B_EONE: begin
        load = 1'b1;
        ch = f2dt_pkg::CH_ZERO + {4'd0, e_ones};
      end
      f2dt_pkg::B_TERM: begin
        load = 1'b1;
        ch = f2dt_pkg::CH_NUL;
      end
      default: begin
        load = 1'b0;
      end
    endcase

    // Output register: load a word when it is free or being taken.
    out_valid_nxt = out_valid_r && !out_ready;
    if (load && emit_ok) begin
      out_valid_nxt = 1'b1;
      out_character_nxt = ch;
      out_last_nxt = (state_r == f2dt_pkg::B_TERM);
      out_char_count_nxt = (state_r == f2dt_pkg::B_TERM) ? cnt_r + 5'd1 : 5'd0;
      cnt_nxt = cnt_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= f2dt_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    a_m_r <= a_m_nxt;
    a_e_r <= a_e_nxt;
    b_m_r <= b_m_nxt;
    b_e_r <= b_e_nxt;
    prod_r <= prod_nxt;
    esum_r <= esum_nxt;
    pass_r <= pass_nxt;
    idx_r <= idx_nxt;
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    bitc_r <= bitc_nxt;
    dig_r <= dig_nxt;
    si_r <= si_nxt;
    cnt_r <= cnt_nxt;
    out_character_r <= out_character_nxt;
    out_last_r <= out_last_nxt;
    out_char_count_r <= out_char_count_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_character = out_character_r;
  assign out_last = out_last_r;
  assign out_char_count = out_char_count_r;

  // Checks on the conversion sequence.
  `F2DT_ASSERT_IMPL(a_last_count, out_valid_r && out_last_r, out_char_count_r != 5'd0, "last word without count")
  `F2DT_ASSERT_IMPL(a_body_nonzero, out_valid_r && !out_last_r, out_character_r != f2dt_pkg::CH_NUL, "zero byte before end")
  `F2DT_ASSERT_IMPL(a_bcd_range, state_r == f2dt_pkg::B_BCD, bitc_r < 6'(BIN_W), "BCD counter overrun")
  `F2DT_ASSERT_IMPL(a_mul_norm, state_r == f2dt_pkg::B_MUL, a_m_r[23] && b_m_r[23], "multiplier operand not normalized")

endmodule

[sv/float_to_decimal_text.sv]
// Converts one binary32 word into ASCII decimal text, one character per output word,
// ending with a zero byte flagged last that also carries the character count. A word
// is classified on entry and parked in a two-entry queue, so a new word is taken while
// the previous text is still being sent. NaN, infinity and zero are sent as fixed texts
// with no conversion. Values from 1 to 1e7 take one rounded multiply by 1e6, then a
// 44-bit binary-to-BCD pass, before their characters. Other values add a search of the
// 84-entry power-of-ten table from the top, one entry a cycle, and a second multiply;
// subnormals first shift their mantissa up one bit a cycle until it is normalized.
module float_to_decimal_text #(
  parameter int MAX_DIGITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_value_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_character,
  output logic        out_last,
  output logic [4:0]  out_char_count
);

  logic            q_full, q_push, q_pop, q_valid;
  f2dt_pkg::item_t push_item, q_item;

  f2dt_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value_bits (in_value_bits),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  f2dt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  f2dt_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_character  (out_character),
    .out_last       (out_last),
    .out_char_count (out_char_count)
  );

endmodule
